@@ hw/rtl/dbh_pkg.sv @@
// ----------------------------------------------------------------------------
// Decade bin histogram package
// Shared widths, defaults, the queue item type and small arithmetic helpers.
// ----------------------------------------------------------------------------
package dbh_pkg;

  localparam int VALUE_W  = 10;
  localparam int INDEX_W  = 6;
  localparam int LOW_W    = 10;
  localparam int COUNT_W  = 11;

  localparam int DEF_NUM_BINS  = 64;
  localparam int DEF_MAX_COUNT = 1024;
  localparam int QUEUE_DEPTH   = 4;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    logic [INDEX_W-1:0] bin;
    logic               last;
    logic [INDEX_W-1:0] top;
  } dbh_entry_t;

  // Exact floor(v / 10) for every 10-bit v, by multiplying with 205 / 2048.
  function automatic logic [6:0] div10(input logic [VALUE_W-1:0] v);
    logic [17:0] prod;
    prod = 18'(v) * 18'd205;
    return prod[17:11];
  endfunction

  // Lower bound of a bin: index times ten, as 8 * index + 2 * index.
  function automatic logic [LOW_W-1:0] bin_low_of(input logic [INDEX_W-1:0] idx);
    return LOW_W'({idx, 3'b000}) + LOW_W'({idx, 1'b0});
  endfunction

endpackage

@@ hw/rtl/dbh_front.sv @@
// ----------------------------------------------------------------------------
// Decade bin histogram front end
// Accepts samples, maps each to its bin and tracks the batch maximum bin.
// ----------------------------------------------------------------------------
module dbh_front #(
  parameter int NUM_BINS = dbh_pkg::DEF_NUM_BINS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [dbh_pkg::VALUE_W-1:0] value,
  input  logic                        last_item,
  output logic                        push,
  output dbh_pkg::dbh_entry_t         entry
);

  localparam logic [dbh_pkg::INDEX_W-1:0] LAST_BIN = dbh_pkg::INDEX_W'(NUM_BINS - 1);

  logic [6:0]                  quot;
  logic [dbh_pkg::INDEX_W-1:0] bin;
  logic [dbh_pkg::INDEX_W-1:0] max_bin;
  logic [dbh_pkg::INDEX_W-1:0] max_bin_next;

  // Samples past the last bin are folded into it.
  always_comb begin
    quot = dbh_pkg::div10(value);
    if (quot > {1'b0, LAST_BIN}) begin
      bin = LAST_BIN;
    end else begin
      bin = quot[dbh_pkg::INDEX_W-1:0];
    end
    max_bin_next = (bin > max_bin) ? bin : max_bin;
  end

  assign push       = start && !busy;
  assign entry.bin  = bin;
  assign entry.last = last_item;
  assign entry.top  = max_bin_next;

  // The bin of the maximum equals the maximum of the bins, so only bins are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bin <= '0;
    end else if (push) begin
      max_bin <= last_item ? '0 : max_bin_next;
    end
  end

endmodule

@@ hw/rtl/dbh_fifo.sv @@
// ----------------------------------------------------------------------------
// Decade bin histogram item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dbh_fifo #(
  parameter int DEPTH = dbh_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dbh_pkg::dbh_entry_t wdata,
  input  logic                pop,
  output dbh_pkg::dbh_entry_t rdata,
  output logic                empty,
  output logic                full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbh_pkg::dbh_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("item popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/dbh_back.sv @@
// ----------------------------------------------------------------------------
// Decade bin histogram back end
// Bin count memory with read-modify-write update and in-order readout.
// ----------------------------------------------------------------------------
module dbh_back #(
  parameter int NUM_BINS  = dbh_pkg::DEF_NUM_BINS,
  parameter int MAX_COUNT = dbh_pkg::DEF_MAX_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  dbh_pkg::dbh_entry_t         entry,
  output logic                        pop,
  output logic                        strobe,
  output logic [dbh_pkg::INDEX_W-1:0] bin_index,
  output logic [dbh_pkg::LOW_W-1:0]   bin_low,
  output logic [dbh_pkg::COUNT_W-1:0] bin_count,
  output logic                        last_bin
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int EXT_W = (CW > dbh_pkg::COUNT_W) ? CW : dbh_pkg::COUNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_COUNT);

  typedef enum logic [1:0] {S_RUN, S_READ, S_HOLD} state_t;

  state_t           state;
  logic [BIN_W-1:0] rd_idx;
  logic [BIN_W-1:0] top_bin;

  // Issue stage.
  logic             a_upd;
  logic             a_emit;
  logic             a_last;
  logic [BIN_W-1:0] a_addr;

  // Execute stage.
  logic             b_upd;
  logic             b_emit;
  logic             b_last;
  logic [BIN_W-1:0] b_addr;

  logic [CW-1:0]       counts [NUM_BINS];
  logic [NUM_BINS-1:0] vld;
  logic [CW-1:0]       rd_data;
  logic                rd_vld;

  // Last write, forwarded to a read of the same bin issued in that cycle.
  logic             wr_v;
  logic [BIN_W-1:0] wr_addr;
  logic [CW-1:0]    wr_data;

  logic [CW-1:0]    cur;
  logic [CW-1:0]    cnt_new;
  logic [EXT_W-1:0] cur_ext;

  always_comb begin
    pop    = 1'b0;
    a_upd  = 1'b0;
    a_emit = 1'b0;
    a_last = 1'b0;
    a_addr = rd_idx;
    case (state)
      S_RUN: begin
        if (!empty) begin
          pop    = 1'b1;
          a_upd  = 1'b1;
          a_addr = entry.bin[BIN_W-1:0];
        end
      end
      S_READ: begin
        a_emit = 1'b1;
        a_last = (rd_idx == top_bin);
      end
      S_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (wr_v && (wr_addr == b_addr)) begin
      cur = wr_data;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    cnt_new = (cur < MAX_C) ? cur + 1'b1 : cur;
    cur_ext = EXT_W'(cur);
  end

  always_ff @(posedge clk) begin
    if (a_upd || a_emit) begin
      rd_data <= counts[a_addr];
    end
    if (b_upd) begin
      counts[b_addr] <= cnt_new;
    end
  end

  // A bin that is not valid reads as zero, so the whole batch clears at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      wr_v <= 1'b0;
    end else begin
      rd_vld  <= vld[a_addr];
      wr_v    <= b_upd;
      wr_addr <= b_addr;
      wr_data <= cnt_new;
      if (b_upd) begin
        vld[b_addr] <= 1'b1;
      end else if (b_emit && b_last) begin
        vld <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      rd_idx   <= '0;
      top_bin  <= '0;
      b_upd    <= 1'b0;
      b_emit   <= 1'b0;
      b_last   <= 1'b0;
      strobe   <= 1'b0;
      last_bin <= 1'b0;
    end else begin
      b_upd  <= a_upd;
      b_emit <= a_emit;
      b_last <= a_last;
      b_addr <= a_addr;
      strobe <= b_emit;
      if (b_emit) begin
        bin_index <= dbh_pkg::INDEX_W'(b_addr);
        bin_low   <= dbh_pkg::bin_low_of(dbh_pkg::INDEX_W'(b_addr));
        bin_count <= cur_ext[dbh_pkg::COUNT_W-1:0];
        last_bin  <= b_last;
      end
      case (state)
        S_RUN: begin
          if (!empty && entry.last) begin
            state   <= S_READ;
            rd_idx  <= '0;
            top_bin <= entry.top[BIN_W-1:0];
          end
        end
        S_READ: begin
          if (a_last) begin
            state <= S_HOLD;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_HOLD: begin
          state <= S_RUN;
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_op: assert property (@(posedge clk) disable iff (rst) !(b_upd && b_emit))
    else $error("update and readout in the execute stage at once");
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_bin) |-> (vld == '0))
    else $error("bins not cleared with the final result");
  a_readout_run: assert property (@(posedge clk) disable iff (rst)
    (b_emit && !b_last) |=> b_emit)
    else $error("readout interrupted before its final bin");
  a_hold_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> ($past(state) == S_READ))
    else $error("hold entered without a readout");
`endif

endmodule

@@ hw/rtl/decade_bin_histogram_core.sv @@
// ----------------------------------------------------------------------------
// Decade bin histogram core
// Counts samples into bins ten wide and reads the bins out after each batch.
// ----------------------------------------------------------------------------
// One sample is accepted per cycle while the four-item queue has room.
// With the queue empty, the back end pops the last item of a batch and enters readout;
// each bin read passes the execute stage and output registers, one bin per cycle. The
// readout keeps the back end from taking items while reading bins zero to top bin, one
// per cycle, and while the bins clear. Results cannot be stalled by the receiver.
// Synchronous reset clears all bins, the batch maximum and the queue.
module decade_bin_histogram_core #(
  parameter int NUM_BINS  = dbh_pkg::DEF_NUM_BINS,
  parameter int MAX_COUNT = dbh_pkg::DEF_MAX_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dbh_pkg::VALUE_W-1:0] value,
  input  logic                        last_item,
  output logic                        strobe,
  output logic [dbh_pkg::INDEX_W-1:0] bin_index,
  output logic [dbh_pkg::LOW_W-1:0]   bin_low,
  output logic [dbh_pkg::COUNT_W-1:0] bin_count,
  output logic                        last_bin
);

  logic                push;
  logic                pop;
  logic                empty;
  logic                full;
  dbh_pkg::dbh_entry_t in_entry;
  dbh_pkg::dbh_entry_t out_entry;

  assign busy = full;

  dbh_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .last_item (last_item),
    .push      (push),
    .entry     (in_entry)
  );

  dbh_fifo #(
    .DEPTH (dbh_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_entry),
    .pop   (pop),
    .rdata (out_entry),
    .empty (empty),
    .full  (full)
  );

  dbh_back #(
    .NUM_BINS  (NUM_BINS),
    .MAX_COUNT (MAX_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .entry     (out_entry),
    .pop       (pop),
    .strobe    (strobe),
    .bin_index (bin_index),
    .bin_low   (bin_low),
    .bin_count (bin_count),
    .last_bin  (last_bin)
  );

endmodule
